/* design/mpps_pkg.sv */
// Package for the motor power-path sequencer: shared widths, reset values,
// register indexes, the divide-by-90 reciprocal and the config/result structs.
// No dependencies.
`default_nettype none

package mpps_pkg;

   localparam int unsigned DUTY_FULL_SCALE_DEFAULT = 32767;

   localparam int unsigned DUTY_W  = 15;
   localparam int unsigned MV_W    = 16;
   localparam int unsigned MS_W    = 16;
   localparam int unsigned TICK_W  = 10;
   localparam int unsigned ADDR_W  = 5;
   localparam int unsigned DATA_W  = 32;

   // (89*c + FS + 45) / 90 by reciprocal: exact for numerators below 2^22
   localparam int unsigned NUM_W       = 22;
   localparam int unsigned RECIP_W     = 23;
   localparam int unsigned PROD_W      = NUM_W + RECIP_W;
   localparam int unsigned RECIP_SHIFT = 29;
   localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 23'd5965233;
   localparam logic [NUM_W-1:0]   REMAP_SLOPE = 22'd89;
   localparam int unsigned        REMAP_ROUND = 45;

   localparam logic [MV_W-1:0]   SUPPLY_HIGH_RESET    = 16'd24000;
   localparam logic [MV_W-1:0]   SUPPLY_LOW_RESET     = 16'd23000;
   localparam logic [MV_W-1:0]   BATTERY_CUTOFF_RESET = 16'd21000;
   localparam logic [DUTY_W-1:0] DUTY_CAP_RESET       = 15'd19660;
   localparam logic [MS_W-1:0]   HOLD_RESET           = 16'd500;
   localparam logic [MS_W-1:0]   STOP_DELAY_RESET     = 16'd5000;

   typedef enum logic [2:0] {
      REG_SUPPLY_HIGH    = 3'd0,
      REG_SUPPLY_LOW     = 3'd1,
      REG_BATTERY_CUTOFF = 3'd2,
      REG_DUTY_CAP       = 3'd3,
      REG_HOLD           = 3'd4,
      REG_STOP_DELAY     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [MV_W-1:0]   supply_high_mv;
      logic [MV_W-1:0]   supply_low_mv;
      logic [MV_W-1:0]   battery_cutoff_mv;
      logic [DUTY_W-1:0] supply_duty_cap;
      logic [MS_W-1:0]   hold_ms;
      logic [MS_W-1:0]   stop_delay_ms;
   } cfg_type;

   typedef struct packed {
      logic [DUTY_W-1:0] pulse_duty;
      logic              drive_en;
      logic              battery_rail_enable;
      logic              supply_rail_enable;
      logic              charge_en;
      logic              source_is_supply;
      logic              motor_running;
      logic              system_off_request;
   } rsp_type;

endpackage

`default_nettype wire

/* design/mpps_csr.sv */
// Configuration register file behind the APB-style port.
// Depends on mpps_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module mpps_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [mpps_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire logic [mpps_pkg::DATA_W-1:0]   csr_pwdata,
   output logic      [mpps_pkg::DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready,
   output mpps_pkg::cfg_type                  cfg
);

   mpps_pkg::cfg_type       cfg_ff;
   mpps_pkg::cfg_type       cfg_in;
   mpps_pkg::csr_index_type index;
   logic                    write_en;

   assign index      = mpps_pkg::csr_index_type'(csr_paddr[mpps_pkg::ADDR_W-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            mpps_pkg::REG_SUPPLY_HIGH:    cfg_in.supply_high_mv    = csr_pwdata[15:0];
            mpps_pkg::REG_SUPPLY_LOW:     cfg_in.supply_low_mv     = csr_pwdata[15:0];
            mpps_pkg::REG_BATTERY_CUTOFF: cfg_in.battery_cutoff_mv = csr_pwdata[15:0];
            mpps_pkg::REG_DUTY_CAP:       cfg_in.supply_duty_cap   = csr_pwdata[14:0];
            mpps_pkg::REG_HOLD:           cfg_in.hold_ms           = csr_pwdata[15:0];
            mpps_pkg::REG_STOP_DELAY:     cfg_in.stop_delay_ms     = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         mpps_pkg::REG_SUPPLY_HIGH:    csr_prdata = {16'd0, cfg_ff.supply_high_mv};
         mpps_pkg::REG_SUPPLY_LOW:     csr_prdata = {16'd0, cfg_ff.supply_low_mv};
         mpps_pkg::REG_BATTERY_CUTOFF: csr_prdata = {16'd0, cfg_ff.battery_cutoff_mv};
         mpps_pkg::REG_DUTY_CAP:       csr_prdata = {17'd0, cfg_ff.supply_duty_cap};
         mpps_pkg::REG_HOLD:           csr_prdata = {16'd0, cfg_ff.hold_ms};
         mpps_pkg::REG_STOP_DELAY:     csr_prdata = {16'd0, cfg_ff.stop_delay_ms};
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.supply_high_mv    <= mpps_pkg::SUPPLY_HIGH_RESET;
         cfg_ff.supply_low_mv     <= mpps_pkg::SUPPLY_LOW_RESET;
         cfg_ff.battery_cutoff_mv <= mpps_pkg::BATTERY_CUTOFF_RESET;
         cfg_ff.supply_duty_cap   <= mpps_pkg::DUTY_CAP_RESET;
         cfg_ff.hold_ms           <= mpps_pkg::HOLD_RESET;
         cfg_ff.stop_delay_ms     <= mpps_pkg::STOP_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* design/mpps_remap.sv */
// Speed command remap: above a tenth of full scale into 0.11..1.0,
// else as is, via a registered reciprocal /90. Depends on mpps_pkg.
`default_nettype none

module mpps_remap #(
   parameter int unsigned DutyFullScale = mpps_pkg::DUTY_FULL_SCALE_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          advance,
   input  wire logic [mpps_pkg::DUTY_W-1:0]   speed_command,
   output logic      [mpps_pkg::DUTY_W-1:0]   duty
);

   localparam int unsigned CMP_W = 19;
   localparam logic [mpps_pkg::NUM_W-1:0] NUM_BIAS =
      mpps_pkg::NUM_W'(DutyFullScale + mpps_pkg::REMAP_ROUND);
   localparam logic [CMP_W-1:0] FS_WORD = CMP_W'(DutyFullScale);
   localparam logic [mpps_pkg::DUTY_W-1:0] DUTY_LIMIT =
      mpps_pkg::DUTY_W'((DutyFullScale > 32767) ? 32767 : DutyFullScale);

   logic [mpps_pkg::NUM_W-1:0]  numer;
   logic [mpps_pkg::PROD_W-1:0] prod;
   logic [CMP_W-1:0]            tenfold;
   logic                        above_in;
   logic [mpps_pkg::QUOT_W-1:0] quot_ff;
   logic                        above_ff;
   logic [mpps_pkg::DUTY_W-1:0] cmd_ff;
   logic [mpps_pkg::QUOT_W-1:0] pick;

   assign numer    = mpps_pkg::NUM_W'(speed_command) * mpps_pkg::REMAP_SLOPE + NUM_BIAS;
   assign prod     = mpps_pkg::PROD_W'(numer) * mpps_pkg::PROD_W'(mpps_pkg::RECIP_MULT);
   assign tenfold  = CMP_W'(speed_command) * CMP_W'(10);
   assign above_in = tenfold > FS_WORD;

   always_ff @(posedge clock) begin
      if (advance) begin
         quot_ff  <= prod[mpps_pkg::PROD_W-1:mpps_pkg::RECIP_SHIFT];
         above_ff <= above_in;
         cmd_ff   <= speed_command;
      end
   end

   assign pick = above_ff ? quot_ff : mpps_pkg::QUOT_W'(cmd_ff);
   assign duty = (pick > mpps_pkg::QUOT_W'(DUTY_LIMIT)) ? DUTY_LIMIT
                                                        : pick[mpps_pkg::DUTY_W-1:0];

endmodule

`default_nettype wire

/* design/mpps_ctrl.sv */
// Per-tick state update: hold/stop timing, charger and source hysteresis,
// shutdown and the registered result word. Depends on mpps_pkg.
`default_nettype none

module mpps_ctrl #(
   parameter int unsigned DutyFullScale = mpps_pkg::DUTY_FULL_SCALE_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire mpps_pkg::cfg_type             cfg,
   input  wire logic [mpps_pkg::DUTY_W-1:0]   duty,
   input  wire logic [mpps_pkg::MV_W-1:0]     supply_mv,
   input  wire logic [mpps_pkg::MV_W-1:0]     pack_mv,
   input  wire logic [mpps_pkg::TICK_W-1:0]   tick_ms,
   input  wire logic                          system_enable_pin,
   input  wire logic                          vbus_present,
   input  wire logic                          supply_detect_pin,
   output mpps_pkg::rsp_type                  result
);

   localparam int unsigned HOLD_RAW = (DutyFullScale + 5) / 10;
   localparam logic [mpps_pkg::DUTY_W-1:0] HOLD_DUTY =
      mpps_pkg::DUTY_W'((HOLD_RAW > 32767) ? 32767 : HOLD_RAW);

   logic [mpps_pkg::MS_W-1:0]   since_ff, since_in;
   logic [mpps_pkg::DUTY_W-1:0] last_ff, last_in;
   logic [mpps_pkg::DUTY_W-1:0] applied_ff, applied_in;
   logic                        motor_ff, motor_in;
   logic                        rail_ff, rail_in;
   logic                        source_ff, source_in;
   logic                        charger_ff, charger_in;
   logic                        off_ff, off_in;
   mpps_pkg::rsp_type           result_ff, result_in;

   logic [mpps_pkg::MS_W:0]     since_sum;
   logic [mpps_pkg::MS_W-1:0]   since_sat;
   logic [mpps_pkg::DUTY_W-1:0] capped;
   logic                        supply_hi;
   logic                        supply_lo;
   logic                        shutdown;
   logic                        charger_mid;
   logic                        source_mid;

   assign since_sum = {1'b0, since_ff} + (mpps_pkg::MS_W + 1)'(tick_ms);
   assign since_sat = since_sum[mpps_pkg::MS_W] ? '1 : since_sum[mpps_pkg::MS_W-1:0];
   assign capped    = (source_ff && (duty > cfg.supply_duty_cap)) ? cfg.supply_duty_cap : duty;
   assign supply_hi = supply_mv > cfg.supply_high_mv;
   assign supply_lo = supply_mv < cfg.supply_low_mv;
   assign shutdown  = !system_enable_pin ||
                      ((pack_mv != '0) && (pack_mv < cfg.battery_cutoff_mv));

   always_comb begin
      since_in   = since_sat;
      last_in    = last_ff;
      applied_in = applied_ff;
      motor_in   = motor_ff;
      if ((capped != '0) || (last_ff != '0)) begin
         if ((capped == '0) && (since_sat < cfg.hold_ms)) begin
            last_in    = HOLD_DUTY;
            applied_in = rail_ff ? HOLD_DUTY : '0;
         end else begin
            since_in   = '0;
            last_in    = capped;
            applied_in = rail_ff ? capped : '0;
         end
         motor_in = 1'b1;
      end else if (motor_ff && (since_sat > cfg.stop_delay_ms)) begin
         motor_in = 1'b0;
      end

      if (supply_hi && !charger_ff) begin
         charger_mid = 1'b1;
      end else if (supply_lo && charger_ff) begin
         charger_mid = 1'b0;
      end else begin
         charger_mid = charger_ff;
      end
      charger_in = charger_mid;
      off_in     = off_ff;
      source_mid = (supply_hi && !source_ff) ? 1'b1 : source_ff;
      if (shutdown) begin
         rail_in   = 1'b0;
         source_in = source_ff;
         if (!vbus_present) begin
            charger_in = supply_detect_pin;
            off_in     = 1'b1;
         end
      end else begin
         source_in = (supply_lo && source_mid) ? 1'b0 : source_mid;
         rail_in   = motor_in;
      end

      // sticky power off: freeze everything
      if (off_ff) begin
         since_in   = since_ff;
         last_in    = last_ff;
         applied_in = applied_ff;
         motor_in   = motor_ff;
         rail_in    = rail_ff;
         source_in  = source_ff;
         charger_in = charger_ff;
         off_in     = off_ff;
      end

      result_in.pulse_duty          = rail_in ? applied_in : '0;
      result_in.drive_en            = rail_in;
      result_in.battery_rail_enable = rail_in && !source_in;
      result_in.supply_rail_enable  = rail_in && source_in;
      result_in.charge_en           = charger_in;
      result_in.source_is_supply    = source_in;
      result_in.motor_running       = motor_in;
      result_in.system_off_request  = off_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         since_ff   <= '0;
         last_ff    <= '0;
         applied_ff <= '0;
         motor_ff   <= 1'b0;
         rail_ff    <= 1'b0;
         source_ff  <= 1'b0;
         charger_ff <= 1'b0;
         off_ff     <= 1'b0;
      end else if (step) begin
         since_ff   <= since_in;
         last_ff    <= last_in;
         applied_ff <= applied_in;
         motor_ff   <= motor_in;
         rail_ff    <= rail_in;
         source_ff  <= source_in;
         charger_ff <= charger_in;
         off_ff     <= off_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

/* design/motor_power_path_sequencer_core.sv */
// Top level of the motor power-path sequencer: handshake pipeline around the
// remap multiplier and the state update. Uses mpps_pkg, mpps_csr,
// mpps_remap and mpps_ctrl.
//
//   channel   direction  handshake          carries
//   req_*     in         req_valid/ready    one tick word: command, voltages, tick, pins
//   rsp_*     out        rsp_valid/ready    one result word per tick
//   csr_*     in/out     APB psel/penable   six configuration registers
//
// Three stages: input register, remap product register, state/result register.
// One word is accepted every cycle while the result is not stalled.
// Throughput is set by the single state update in mpps_ctrl, one per cycle.
// A stalled result holds the whole pipeline; req_ready follows rsp_ready then.
// Reset clears the stage valids and all tick state; registers take reset values.
`default_nettype none

module motor_power_path_sequencer_core #(
   parameter int unsigned DutyFullScale = mpps_pkg::DUTY_FULL_SCALE_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [mpps_pkg::DUTY_W-1:0]   req_speed_command,
   input  wire logic [mpps_pkg::MV_W-1:0]     req_supply_mv,
   input  wire logic [mpps_pkg::MV_W-1:0]     req_pack_mv,
   input  wire logic [mpps_pkg::TICK_W-1:0]   req_tick_ms,
   input  wire logic                          req_system_enable_pin,
   input  wire logic                          req_vbus_present,
   input  wire logic                          req_supply_detect_pin,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [mpps_pkg::DUTY_W-1:0]   rsp_pulse_duty,
   output logic                               rsp_drive_en,
   output logic                               rsp_battery_rail_enable,
   output logic                               rsp_supply_rail_enable,
   output logic                               rsp_charge_en,
   output logic                               rsp_source_is_supply,
   output logic                               rsp_motor_running,
   output logic                               rsp_system_off_request,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [mpps_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire logic [mpps_pkg::DATA_W-1:0]   csr_pwdata,
   output logic      [mpps_pkg::DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready
);

   localparam logic [mpps_pkg::DUTY_W-1:0] DUTY_LIMIT =
      mpps_pkg::DUTY_W'((DutyFullScale > 32767) ? 32767 : DutyFullScale);

   mpps_pkg::cfg_type           cfg;
   mpps_pkg::rsp_type           result;
   logic                        advance;
   logic                        s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic [mpps_pkg::DUTY_W-1:0] s1_cmd_ff;
   logic [mpps_pkg::MV_W-1:0]   s1_supply_ff, s2_supply_ff;
   logic [mpps_pkg::MV_W-1:0]   s1_battery_ff, s2_battery_ff;
   logic [mpps_pkg::TICK_W-1:0] s1_tick_ff, s2_tick_ff;
   logic [2:0]                  s1_pins_ff, s2_pins_ff;
   logic [mpps_pkg::DUTY_W-1:0] remap_duty;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff     <= req_speed_command;
         s1_supply_ff  <= req_supply_mv;
         s1_battery_ff <= req_pack_mv;
         s1_tick_ff    <= req_tick_ms;
         s1_pins_ff    <= {req_system_enable_pin, req_vbus_present, req_supply_detect_pin};
         s2_supply_ff  <= s1_supply_ff;
         s2_battery_ff <= s1_battery_ff;
         s2_tick_ff    <= s1_tick_ff;
         s2_pins_ff    <= s1_pins_ff;
      end
   end

   mpps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mpps_remap #(.DutyFullScale(DutyFullScale)) u_remap (
      .clock         (clock),
      .advance       (advance),
      .speed_command (s1_cmd_ff),
      .duty          (remap_duty)
   );

   mpps_ctrl #(.DutyFullScale(DutyFullScale)) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .step              (advance && s2_valid_ff),
      .cfg               (cfg),
      .duty              (remap_duty),
      .supply_mv         (s2_supply_ff),
      .pack_mv           (s2_battery_ff),
      .tick_ms           (s2_tick_ff),
      .system_enable_pin (s2_pins_ff[2]),
      .vbus_present      (s2_pins_ff[1]),
      .supply_detect_pin (s2_pins_ff[0]),
      .result            (result)
   );

   assign rsp_pulse_duty          = result.pulse_duty;
   assign rsp_drive_en            = result.drive_en;
   assign rsp_battery_rail_enable = result.battery_rail_enable;
   assign rsp_supply_rail_enable  = result.supply_rail_enable;
   assign rsp_charge_en           = result.charge_en;
   assign rsp_source_is_supply    = result.source_is_supply;
   assign rsp_motor_running       = result.motor_running;
   assign rsp_system_off_request  = result.system_off_request;

   a_rail_split: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_en == (rsp_battery_rail_enable || rsp_supply_rail_enable))
                    && !(rsp_battery_rail_enable && rsp_supply_rail_enable))
      else $error("rail enables inconsistent with drive enable");

   a_idle_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_drive_en) |-> (rsp_pulse_duty == '0))
      else $error("nonzero duty with rail inactive");

   a_duty_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pulse_duty <= DUTY_LIMIT))
      else $error("duty above full scale");

   a_off_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_system_off_request) |=>
         (!rsp_valid || rsp_system_off_request))
      else $error("system off request dropped");

endmodule

`default_nettype wire

/* tb/motor_power_path_sequencer_core_test.sv */
// Self-checking test of motor_power_path_sequencer_core: drives tick words and APB
// register writes, predicts each result word in a small scoreboard class and compares.
// Depends on mpps_pkg and the core RTL only.
`default_nettype none

module motor_power_path_sequencer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FULL_SCALE = mpps_pkg::DUTY_FULL_SCALE_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_OFF_CYCLES = 150;
   localparam logic [mpps_pkg::ADDR_W-1:0] SPARE_ADDR = 5'd24;

   typedef struct packed {
      logic [mpps_pkg::DUTY_W-1:0] speed_command;
      logic [mpps_pkg::MV_W-1:0]   supply_mv;
      logic [mpps_pkg::MV_W-1:0]   pack_mv;
      logic [mpps_pkg::TICK_W-1:0] tick_ms;
      logic                        system_enable_pin;
      logic                        vbus_present;
      logic                        supply_detect_pin;
   } tick_word_type;

   typedef enum int { SEG_RUN, SEG_QUIET, SEG_NOISE } segment_type;

   class tick_board_type;
      mpps_pkg::cfg_type cfg;
      int unsigned       idle_ms;
      int unsigned       held_duty;
      int unsigned       drive_duty;
      int unsigned       request_duty;
      bit                spinning;
      bit                rail_on;
      bit                on_supply;
      bit                charging;
      bit                shut_off;
      mpps_pkg::rsp_type expected_results[$];
      int                errors;

      function new();
         cfg.supply_high_mv    = mpps_pkg::SUPPLY_HIGH_RESET;
         cfg.supply_low_mv     = mpps_pkg::SUPPLY_LOW_RESET;
         cfg.battery_cutoff_mv = mpps_pkg::BATTERY_CUTOFF_RESET;
         cfg.supply_duty_cap   = mpps_pkg::DUTY_CAP_RESET;
         cfg.hold_ms           = mpps_pkg::HOLD_RESET;
         cfg.stop_delay_ms     = mpps_pkg::STOP_DELAY_RESET;
         idle_ms = 0;
         held_duty = 0;
         drive_duty = 0;
         request_duty = 0;
         spinning = 0;
         rail_on = 0;
         on_supply = 0;
         charging = 0;
         shut_off = 0;
         errors = 0;
      endfunction

      function void set_register(mpps_pkg::csr_index_type idx,
                                 logic [mpps_pkg::DATA_W-1:0] value);
         case (idx)
            mpps_pkg::REG_SUPPLY_HIGH:    cfg.supply_high_mv    = value[mpps_pkg::MV_W-1:0];
            mpps_pkg::REG_SUPPLY_LOW:     cfg.supply_low_mv     = value[mpps_pkg::MV_W-1:0];
            mpps_pkg::REG_BATTERY_CUTOFF: cfg.battery_cutoff_mv = value[mpps_pkg::MV_W-1:0];
            mpps_pkg::REG_DUTY_CAP:       cfg.supply_duty_cap   = value[mpps_pkg::DUTY_W-1:0];
            mpps_pkg::REG_HOLD:           cfg.hold_ms           = value[mpps_pkg::MS_W-1:0];
            mpps_pkg::REG_STOP_DELAY:     cfg.stop_delay_ms     = value[mpps_pkg::MS_W-1:0];
            default: ;
         endcase
      endfunction

      function bit goes_down(tick_word_type w);
         return !w.system_enable_pin ||
                (w.pack_mv != 0 && w.pack_mv < cfg.battery_cutoff_mv);
      endfunction

      function void note_tick(tick_word_type w);
         int unsigned       c;
         int unsigned       d;
         mpps_pkg::rsp_type r;
         if (!shut_off) begin
            idle_ms = idle_ms + w.tick_ms;
            if (idle_ms > 65535) idle_ms = 65535;
            c = w.speed_command;
            d = c;
            if (10 * c > FULL_SCALE) d = (89 * c + FULL_SCALE + 45) / 90;
            if (d > FULL_SCALE) d = FULL_SCALE;
            if (on_supply && d > cfg.supply_duty_cap) d = cfg.supply_duty_cap;
            request_duty = d;
            if (d != 0 || held_duty != 0) begin
               if (d == 0 && idle_ms < cfg.hold_ms) d = (FULL_SCALE + 5) / 10;
               else idle_ms = 0;
               held_duty = d;
               spinning = 1;
               drive_duty = rail_on ? d : 0;
            end else if (spinning && request_duty == 0 && idle_ms > cfg.stop_delay_ms) begin
               spinning = 0;
            end
            if (w.supply_mv > cfg.supply_high_mv && !charging) charging = 1;
            else if (w.supply_mv < cfg.supply_low_mv && charging) charging = 0;
            if (goes_down(w)) begin
               rail_on = 0;
               if (!w.vbus_present) begin
                  charging = w.supply_detect_pin;
                  shut_off = 1;
               end
            end else begin
               if (w.supply_mv > cfg.supply_high_mv && !on_supply) on_supply = 1;
               if (w.supply_mv < cfg.supply_low_mv && on_supply) on_supply = 0;
               rail_on = spinning;
            end
         end
         r.pulse_duty          = rail_on ? drive_duty[mpps_pkg::DUTY_W-1:0] : '0;
         r.drive_en            = rail_on;
         r.battery_rail_enable = rail_on && !on_supply;
         r.supply_rail_enable  = rail_on && on_supply;
         r.charge_en           = charging;
         r.source_is_supply    = on_supply;
         r.motor_running       = spinning;
         r.system_off_request  = shut_off;
         expected_results.push_back(r);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(mpps_pkg::rsp_type got);
         mpps_pkg::rsp_type want;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: result word with nothing expected, actual %h", $time, got);
            return;
         end
         want = expected_results.pop_front();
         compare_field("pulse_duty", want.pulse_duty, got.pulse_duty);
         compare_field("drive_en", want.drive_en, got.drive_en);
         compare_field("battery_rail_enable", want.battery_rail_enable,
                       got.battery_rail_enable);
         compare_field("supply_rail_enable", want.supply_rail_enable,
                       got.supply_rail_enable);
         compare_field("charge_en", want.charge_en, got.charge_en);
         compare_field("source_is_supply", want.source_is_supply, got.source_is_supply);
         compare_field("motor_running", want.motor_running, got.motor_running);
         compare_field("system_off_request", want.system_off_request,
                       got.system_off_request);
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [mpps_pkg::DUTY_W-1:0]   req_speed_command = '0;
   logic [mpps_pkg::MV_W-1:0]     req_supply_mv = '0;
   logic [mpps_pkg::MV_W-1:0]     req_pack_mv = '0;
   logic [mpps_pkg::TICK_W-1:0]   req_tick_ms = '0;
   logic                          req_system_enable_pin = 1'b1;
   logic                          req_vbus_present = 1'b0;
   logic                          req_supply_detect_pin = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [mpps_pkg::DUTY_W-1:0]   rsp_pulse_duty;
   logic                          rsp_drive_en;
   logic                          rsp_battery_rail_enable;
   logic                          rsp_supply_rail_enable;
   logic                          rsp_charge_en;
   logic                          rsp_source_is_supply;
   logic                          rsp_motor_running;
   logic                          rsp_system_off_request;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [mpps_pkg::ADDR_W-1:0]   csr_paddr = '0;
   logic [mpps_pkg::DATA_W-1:0]   csr_pwdata = '0;
   logic [mpps_pkg::DATA_W-1:0]   csr_prdata;
   logic                          csr_pready;

   tick_board_type board = new();
   int   send_idle_pct = 0;
   int   stall_pct = 0;
   bit   hold_off_due = 0;
   int   hold_off_left = 0;
   int unsigned cycles = 0;

   motor_power_path_sequencer_core dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_speed_command       (req_speed_command),
      .req_supply_mv           (req_supply_mv),
      .req_pack_mv             (req_pack_mv),
      .req_tick_ms             (req_tick_ms),
      .req_system_enable_pin   (req_system_enable_pin),
      .req_vbus_present        (req_vbus_present),
      .req_supply_detect_pin   (req_supply_detect_pin),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_pulse_duty          (rsp_pulse_duty),
      .rsp_drive_en            (rsp_drive_en),
      .rsp_battery_rail_enable (rsp_battery_rail_enable),
      .rsp_supply_rail_enable  (rsp_supply_rail_enable),
      .rsp_charge_en           (rsp_charge_en),
      .rsp_source_is_supply    (rsp_source_is_supply),
      .rsp_motor_running       (rsp_motor_running),
      .rsp_system_off_request  (rsp_system_off_request),
      .csr_psel                (csr_psel),
      .csr_penable             (csr_penable),
      .csr_pwrite              (csr_pwrite),
      .csr_paddr               (csr_paddr),
      .csr_pwdata              (csr_pwdata),
      .csr_prdata              (csr_prdata),
      .csr_pready              (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin : collect
      mpps_pkg::rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_pulse_duty, rsp_drive_en, rsp_battery_rail_enable,
                rsp_supply_rail_enable, rsp_charge_en, rsp_source_is_supply,
                rsp_motor_running, rsp_system_off_request};
         board.check_result(got);
      end
      if (hold_off_due) begin
         hold_off_due = 0;
         hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_word(input tick_word_type w);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_speed_command     <= w.speed_command;
      req_supply_mv         <= w.supply_mv;
      req_pack_mv           <= w.pack_mv;
      req_tick_ms           <= w.tick_ms;
      req_system_enable_pin <= w.system_enable_pin;
      req_vbus_present      <= w.vbus_present;
      req_supply_detect_pin <= w.supply_detect_pin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_tick(w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [mpps_pkg::ADDR_W-1:0] addr,
                            input logic [mpps_pkg::DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic set_reg(input mpps_pkg::csr_index_type idx, input int unsigned value);
      logic [mpps_pkg::DATA_W-1:0] word;
      word = value | ($urandom << 16);
      csr_write({idx, 2'b00}, word);
      board.set_register(idx, word);
   endtask

   task automatic program_config(input int unsigned high, input int unsigned low,
                                 input int unsigned cutoff, input int unsigned cap,
                                 input int unsigned hold, input int unsigned stop);
      set_reg(mpps_pkg::REG_SUPPLY_HIGH, high);
      set_reg(mpps_pkg::REG_SUPPLY_LOW, low);
      set_reg(mpps_pkg::REG_BATTERY_CUTOFF, cutoff);
      set_reg(mpps_pkg::REG_DUTY_CAP, cap);
      set_reg(mpps_pkg::REG_HOLD, hold);
      set_reg(mpps_pkg::REG_STOP_DELAY, stop);
      csr_write(SPARE_ADDR, $urandom);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_config();
      int unsigned high;
      high = $urandom_range(20000, 28000);
      program_config(high, high - $urandom_range(0, 2000), $urandom_range(0, 24000),
                     $urandom_range(0, 32767), $urandom_range(0, 3000),
                     $urandom_range(0, 8000));
   endtask

   function automatic tick_word_type mk(int unsigned cmd, int unsigned supply,
                                        int unsigned battery, int unsigned tick,
                                        bit en, bit vbus, bit detect);
      tick_word_type w;
      w.speed_command     = cmd[mpps_pkg::DUTY_W-1:0];
      w.supply_mv         = supply[mpps_pkg::MV_W-1:0];
      w.pack_mv           = battery[mpps_pkg::MV_W-1:0];
      w.tick_ms           = tick[mpps_pkg::TICK_W-1:0];
      w.system_enable_pin = en;
      w.vbus_present      = vbus;
      w.supply_detect_pin = detect;
      return w;
   endfunction

   function automatic tick_word_type random_word(segment_type seg, bit allow_off);
      tick_word_type w;
      logic [95:0]   noise;
      int unsigned   lo;
      int unsigned   hi;
      int unsigned   cut;
      noise = {$urandom, $urandom, $urandom};
      w = noise[$bits(tick_word_type)-1:0];
      if (seg != SEG_NOISE) begin
         lo = board.cfg.supply_low_mv;
         hi = board.cfg.supply_high_mv;
         if (lo > hi) begin
            lo = board.cfg.supply_high_mv;
            hi = board.cfg.supply_low_mv;
         end
         lo = (lo > 300) ? lo - 300 : 0;
         hi = (hi + 300 > 65535) ? 65535 : hi + 300;
         cut = board.cfg.battery_cutoff_mv;
         case ($urandom_range(7))
            0: w.supply_mv = '0;
            1: w.supply_mv = '1;
            2: w.supply_mv = mpps_pkg::MV_W'($urandom);
            default: w.supply_mv = mpps_pkg::MV_W'($urandom_range(lo, hi));
         endcase
         case ($urandom_range(7))
            0: w.pack_mv = '0;
            1: w.pack_mv = mpps_pkg::MV_W'($urandom);
            2: w.pack_mv = mpps_pkg::MV_W'($urandom_range((cut > 50) ? cut - 50 : 0,
                                             (cut + 50 > 65535) ? 65535 : cut + 50));
            default: w.pack_mv = mpps_pkg::MV_W'($urandom_range(cut, 65535));
         endcase
         case ($urandom_range(5))
            0: w.tick_ms = '0;
            1: w.tick_ms = '1;
            default: w.tick_ms = mpps_pkg::TICK_W'($urandom_range(0, 1023));
         endcase
         w.system_enable_pin = ($urandom_range(19) != 0);
         if (seg == SEG_QUIET) begin
            w.speed_command = '0;
         end else begin
            case ($urandom_range(5))
               0: w.speed_command = mpps_pkg::DUTY_W'($urandom_range(3270, 3285));
               1: w.speed_command = mpps_pkg::DUTY_W'($urandom_range(32700, 32767));
               2: w.speed_command = mpps_pkg::DUTY_W'($urandom_range(1, 3276));
               default: w.speed_command = mpps_pkg::DUTY_W'($urandom_range(1, 32767));
            endcase
         end
      end
      if (!allow_off && board.goes_down(w)) w.vbus_present = 1'b1;
      return w;
   endfunction

   task automatic run_random(input int n);
      int sent;
      int len;
      int pick;
      segment_type seg;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(9);
         if (pick < 5) begin
            seg = SEG_RUN;
            len = $urandom_range(1, 8);
         end else if (pick < 8) begin
            seg = SEG_QUIET;
            len = $urandom_range(1, 20);
         end else begin
            seg = SEG_NOISE;
            len = $urandom_range(1, 4);
         end
         repeat (len) begin
            send_word(random_word(seg, 1'b0));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(mk(0, 0, 0, 0, 1, 0, 0));
      send_word(mk(1, 23500, 30000, 5, 1, 0, 1));
      send_word(mk(3276, 23500, 30000, 5, 1, 0, 0));
      send_word(mk(3277, 23500, 30000, 5, 1, 0, 0));
      send_word(mk(32767, 23500, 65535, 1023, 1, 1, 1));
      send_word(mk(32767, 65535, 30000, 10, 1, 0, 0));
      send_word(mk(32767, 65535, 30000, 10, 1, 0, 0));
      send_word(mk(0, 65535, 30000, 100, 1, 0, 0));
      send_word(mk(0, 65535, 30000, 300, 1, 0, 0));
      send_word(mk(0, 65535, 30000, 200, 1, 0, 0));
      repeat (6) send_word(mk(0, 23500, 30000, 1023, 1, 0, 0));
      send_word(mk(1000, 0, 30000, 1, 1, 0, 0));
      send_word(mk(32767, 24000, 0, 1023, 1, 0, 1));
      send_word(mk(500, 23000, 20999, 1, 1, 1, 0));
      send_word(mk(500, 23000, 21000, 1, 0, 1, 1));
      send_word(mk(500, 23000, 21000, 0, 1, 0, 0));
      send_word(mk(32767, 65535, 65535, 1023, 1, 0, 1));
      drain();

      run_random(400);
      drain();

      program_config(65535, 0, 0, 32767, 0, 0);
      send_idle_pct = 78;
      run_random(300);
      drain();

      program_config(0, 65535, 65535, 0, 65535, 65535);
      send_idle_pct = 0;
      stall_pct = 78;
      run_random(300);
      drain();

      random_config();
      send_idle_pct = 29;
      stall_pct = 29;
      run_random(300);
      drain();

      random_config();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off_due = 1;
      run_random(300);
      drain();

      random_config();
      send_idle_pct = 29;
      stall_pct = 78;
      run_random(400);

      send_word(mk(20000, 65535, 65535, 10, 1, 0, 0));
      send_word(mk(20000, 65535, 65535, 10, 0, 0, 1'($urandom_range(1))));
      repeat (8) send_word(random_word(SEG_NOISE, 1'b1));
      drain();

      if (board.errors == 0 && board.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
